[sv/gtg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtg_pkg
// Shared widths, register indexes, types and helpers for the grid tile
// geometry block.
// ----------------------------------------------------------------------------
package gtg_pkg;

  localparam int DIM_W     = 13;
  localparam int POS_W     = 12;
  localparam int IDX_W     = 24;
  localparam int REG_IDX_W = 3;
  localparam int CNT_W     = 4;

  localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

  localparam logic [REG_IDX_W-1:0] REG_GRID_ROWS    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GRID_COLUMNS = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd5;

  typedef enum logic [1:0] {
    SU_LOAD,
    SU_DIVIDE,
    SU_FINISH,
    SU_READY
  } setup_state_t;

  // Derived consts; user, not block, holds stable with items in flight
  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] wbase;
    logic [DIM_W-1:0] hbase;
    logic [POS_W-1:0] wres;
    logic [POS_W-1:0] hres;
    logic [POS_W-1:0] oxm;
    logic [POS_W-1:0] oym;
  } setup_t;

  typedef struct packed {
    logic             q;
    logic [POS_W-1:0] rem;
  } rstep_t;

  typedef struct packed {
    logic [IDX_W-1:0] num;
    logic [IDX_W-1:0] quo;
    logic [POS_W-1:0] rem;
    logic [POS_W-1:0] acc;
  } div_t;

  typedef struct packed {
    logic [POS_W-1:0] prod;
    logic [POS_W-1:0] mcol;
    logic [DIM_W-1:0] tw;
    logic [DIM_W-1:0] th;
    logic             beyond;
    logic [POS_W-1:0] mrow;
    logic [POS_W-1:0] ty;
  } mul_t;

  typedef struct packed {
    logic [POS_W-1:0] sx;
    logic [POS_W-1:0] ty;
    logic [DIM_W-1:0] tw;
    logic [DIM_W-1:0] th;
    logic             beyond;
  } add_t;

  typedef struct packed {
    logic [DIM_W-1:0] tw;
    logic [DIM_W-1:0] th;
    logic [POS_W-1:0] tx;
    logic [POS_W-1:0] ty;
    logic             beyond;
  } res_t;

  // One restoring division step; rem must be below dvsr on entry
  function automatic rstep_t rdiv_step(input logic [POS_W-1:0] rem,
                                       input logic bit_in,
                                       input logic [DIM_W-1:0] dvsr);
    logic [DIM_W-1:0] part;
    rstep_t           res;
    part    = {rem, bit_in};
    res.q   = (part >= dvsr);
    res.rem = res.q ? POS_W'(part - dvsr) : part[POS_W-1:0];
    return res;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > MAX_DIM) begin
      res = MAX_DIM;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

[sv/grid_tile_geometry.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_tile_geometry
// Tile rectangle lookup for an image split into a rows-by-columns grid with
// balanced residues and a wrapped grid offset.
// ----------------------------------------------------------------------------
// Takes one tile index per cycle while in_stall is low and returns one result
// per index. Each index passes through the 24-stage restoring divider that
// splits the index into row and column, followed by a multiply stage and two
// modular add stages. After reset and after each configuration write, the
// setup unit derives base sizes, residues and wrapped offsets, during which
// in_stall is high. A two-entry output (register plus skid) keeps input
// flowing while a finished result waits.
module grid_tile_geometry (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [gtg_pkg::IDX_W-1:0]      in_tile_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [gtg_pkg::DIM_W-1:0]      out_tile_w,
  output logic [gtg_pkg::DIM_W-1:0]      out_tile_h,
  output logic [gtg_pkg::POS_W-1:0]      out_tile_x,
  output logic [gtg_pkg::POS_W-1:0]      out_tile_y,
  output logic                           out_index_beyond_grid,
  input  logic                           cfg_wr_en,
  input  logic [gtg_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [gtg_pkg::DIM_W-1:0]      cfg_wr_data
);

  gtg_pkg::setup_t setup;
  logic            busy;

  gtg_setup u_setup (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .setup       (setup),
    .busy        (busy)
  );

  gtg_pkg::div_t div_r   [0:gtg_pkg::IDX_W];
  logic          div_v_r [0:gtg_pkg::IDX_W];
  gtg_pkg::div_t div_nxt [0:gtg_pkg::IDX_W-1];

  gtg_pkg::mul_t mul_r, mul_nxt;
  gtg_pkg::add_t add_r, add_nxt;
  gtg_pkg::res_t res_r, res_nxt;
  gtg_pkg::res_t out_r, skid_r;
  logic          mul_v_r, add_v_r, res_v_r, out_v_r, skid_v_r;

  logic en, arrive, take;

  // quotient bit plus running (row * hbase) mod h
  function automatic gtg_pkg::div_t pipe_step(input gtg_pkg::div_t s,
                                              input gtg_pkg::setup_t c);
    gtg_pkg::rstep_t           d;
    logic [gtg_pkg::DIM_W:0]   a;
    gtg_pkg::div_t             n;
    d = gtg_pkg::rdiv_step(s.rem, s.num[gtg_pkg::IDX_W-1], c.cols);
    a = {1'b0, s.acc, 1'b0} + (d.q ? {1'b0, c.hbase} : '0);
    if (a >= {1'b0, c.h}) begin
      a = a - {1'b0, c.h};
    end
    if (a >= {1'b0, c.h}) begin
      a = a - {1'b0, c.h};
    end
    n.num = {s.num[gtg_pkg::IDX_W-2:0], 1'b0};
    n.quo = {s.quo[gtg_pkg::IDX_W-2:0], d.q};
    n.rem = d.rem;
    n.acc = a[gtg_pkg::POS_W-1:0];
    return n;
  endfunction

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r || busy;
  assign arrive   = en && res_v_r;
  assign take     = out_v_r && !out_stall;

  always_comb begin
    for (int k = 0; k < gtg_pkg::IDX_W; k++) begin
      div_nxt[k] = pipe_step(div_r[k], setup);
    end
  end

  // column offset product, width/height, flag, y partial sum
  always_comb begin
    gtg_pkg::div_t                           s;
    logic [gtg_pkg::POS_W+gtg_pkg::DIM_W-1:0] prod_full;
    logic [gtg_pkg::DIM_W-1:0]               t1;
    logic                                    col_lo, row_lo;
    s         = div_r[gtg_pkg::IDX_W];
    prod_full = (gtg_pkg::POS_W+gtg_pkg::DIM_W)'(s.rem)
              * (gtg_pkg::POS_W+gtg_pkg::DIM_W)'(setup.wbase);
    col_lo    = (s.rem < setup.wres);
    row_lo    = (s.quo < gtg_pkg::IDX_W'(setup.hres));
    t1        = {1'b0, setup.oym} + {1'b0, s.acc};
    mul_nxt.prod   = prod_full[gtg_pkg::POS_W-1:0];
    mul_nxt.mcol   = col_lo ? s.rem : setup.wres;
    mul_nxt.tw     = setup.wbase + gtg_pkg::DIM_W'(col_lo);
    mul_nxt.th     = setup.hbase + gtg_pkg::DIM_W'(row_lo);
    mul_nxt.beyond = (s.quo >= gtg_pkg::IDX_W'(setup.rows));
    mul_nxt.mrow   = row_lo ? s.quo[gtg_pkg::POS_W-1:0] : setup.hres;
    mul_nxt.ty     = (t1 >= setup.h) ? gtg_pkg::POS_W'(t1 - setup.h)
                                     : t1[gtg_pkg::POS_W-1:0];
  end

  always_comb begin
    logic [gtg_pkg::DIM_W-1:0] sx, t2;
    sx = {1'b0, mul_r.prod} + {1'b0, mul_r.mcol};
    t2 = {1'b0, mul_r.ty} + {1'b0, mul_r.mrow};
    add_nxt.sx     = sx[gtg_pkg::POS_W-1:0];
    add_nxt.ty     = (t2 >= setup.h) ? gtg_pkg::POS_W'(t2 - setup.h)
                                     : t2[gtg_pkg::POS_W-1:0];
    add_nxt.tw     = mul_r.tw;
    add_nxt.th     = mul_r.th;
    add_nxt.beyond = mul_r.beyond;
  end

  always_comb begin
    logic [gtg_pkg::DIM_W-1:0] tx;
    tx = {1'b0, setup.oxm} + {1'b0, add_r.sx};
    res_nxt.tx     = (tx >= setup.w) ? gtg_pkg::POS_W'(tx - setup.w)
                                     : tx[gtg_pkg::POS_W-1:0];
    res_nxt.ty     = add_r.ty;
    res_nxt.tw     = add_r.tw;
    res_nxt.th     = add_r.th;
    res_nxt.beyond = add_r.beyond;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= gtg_pkg::IDX_W; k++) begin
        div_v_r[k] <= 1'b0;
      end
      mul_v_r  <= 1'b0;
      add_v_r  <= 1'b0;
      res_v_r  <= 1'b0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (en) begin
        div_v_r[0] <= in_valid && !in_stall;
        for (int k = 0; k < gtg_pkg::IDX_W; k++) begin
          div_v_r[k+1] <= div_v_r[k];
        end
        mul_v_r <= div_v_r[gtg_pkg::IDX_W];
        add_v_r <= mul_v_r;
        res_v_r <= add_v_r;
      end
      if (skid_v_r) begin
        if (take) begin
          skid_v_r <= 1'b0;
        end
      end else if (arrive) begin
        if (out_v_r && !take) begin
          skid_v_r <= 1'b1;
        end else begin
          out_v_r <= 1'b1;
        end
      end else if (take) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r[0].num <= in_tile_index;
      div_r[0].quo <= '0;
      div_r[0].rem <= '0;
      div_r[0].acc <= '0;
      for (int k = 0; k < gtg_pkg::IDX_W; k++) begin
        div_r[k+1] <= div_nxt[k];
      end
      mul_r <= mul_nxt;
      add_r <= add_nxt;
      res_r <= res_nxt;
    end
    if (skid_v_r) begin
      if (take) begin
        out_r <= skid_r;
      end
    end else if (arrive) begin
      if (out_v_r && !take) begin
        skid_r <= res_r;
      end else begin
        out_r <= res_r;
      end
    end
  end

  assign out_valid             = out_v_r;
  assign out_tile_w            = out_r.tw;
  assign out_tile_h            = out_r.th;
  assign out_tile_x            = out_r.tx;
  assign out_tile_y            = out_r.ty;
  assign out_index_beyond_grid = out_r.beyond;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held without an output item");

  a_skid_drains_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(skid_v_r) |-> $past(out_valid && !out_stall))
    else $error("skid entry dropped without output handshake");

  a_setup_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> ({1'b0, setup.oxm} < setup.w) && ({1'b0, setup.oym} < setup.h)
              && ({1'b0, setup.wres} < setup.cols)
              && ({1'b0, setup.hres} < setup.rows))
    else $error("derived grid constants out of range");

endmodule

[sv/gtg_setup.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtg_setup
// Configuration registers and the iterative unit that derives tile base
// sizes, residues and wrapped grid offsets after reset or any write.
// ----------------------------------------------------------------------------
module gtg_setup (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [gtg_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [gtg_pkg::DIM_W-1:0]      cfg_wr_data,
  output gtg_pkg::setup_t                setup,
  output logic                           busy
);

  logic [gtg_pkg::DIM_W-1:0] rows_r, cols_r, w_r, h_r, ox_r, oy_r;

  gtg_pkg::setup_state_t     state_r, state_nxt;
  logic [gtg_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  logic [gtg_pkg::DIM_W-1:0] wn_r, hn_r, xn_r, yn_r;
  logic [gtg_pkg::DIM_W-1:0] wq_r, hq_r;
  logic [gtg_pkg::POS_W-1:0] wr_r, hr_r, xr_r, yr_r;
  logic [gtg_pkg::POS_W-1:0] oxm_r, oym_r;

  gtg_pkg::rstep_t ws, hs, xs, ys;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= gtg_pkg::DIM_W'(1);
      cols_r <= gtg_pkg::DIM_W'(1);
      ox_r   <= '0;
      oy_r   <= '0;
      w_r    <= gtg_pkg::DIM_W'(1);
      h_r    <= gtg_pkg::DIM_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        gtg_pkg::REG_GRID_ROWS:    rows_r <= gtg_pkg::clamp_dim(cfg_wr_data);
        gtg_pkg::REG_GRID_COLUMNS: cols_r <= gtg_pkg::clamp_dim(cfg_wr_data);
        gtg_pkg::REG_ORIGIN_X:     ox_r   <= cfg_wr_data;
        gtg_pkg::REG_ORIGIN_Y:     oy_r   <= cfg_wr_data;
        gtg_pkg::REG_IMAGE_WIDTH:  w_r    <= gtg_pkg::clamp_dim(cfg_wr_data);
        gtg_pkg::REG_IMAGE_HEIGHT: h_r    <= gtg_pkg::clamp_dim(cfg_wr_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    ws = gtg_pkg::rdiv_step(wr_r, wn_r[gtg_pkg::DIM_W-1], cols_r);
    hs = gtg_pkg::rdiv_step(hr_r, hn_r[gtg_pkg::DIM_W-1], rows_r);
    xs = gtg_pkg::rdiv_step(xr_r, xn_r[gtg_pkg::DIM_W-1], w_r);
    ys = gtg_pkg::rdiv_step(yr_r, yn_r[gtg_pkg::DIM_W-1], h_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gtg_pkg::SU_LOAD;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      gtg_pkg::SU_LOAD: begin
        state_nxt = gtg_pkg::SU_DIVIDE;
        cnt_nxt   = '0;
      end
      gtg_pkg::SU_DIVIDE: begin
        if (cnt_r == gtg_pkg::CNT_W'(gtg_pkg::DIM_W - 1)) begin
          state_nxt = gtg_pkg::SU_FINISH;
        end else begin
          cnt_nxt = cnt_r + gtg_pkg::CNT_W'(1);
        end
      end
      gtg_pkg::SU_FINISH: state_nxt = gtg_pkg::SU_READY;
      gtg_pkg::SU_READY:  state_nxt = gtg_pkg::SU_READY;
      default:            state_nxt = gtg_pkg::SU_LOAD;
    endcase
    if (cfg_wr_en) begin
      state_nxt = gtg_pkg::SU_LOAD;
    end
  end

  // offsets divide by magnitude; negative remainders fold back at the end
  always_ff @(posedge clk) begin
    case (state_r)
      gtg_pkg::SU_LOAD: begin
        wn_r <= w_r;
        hn_r <= h_r;
        xn_r <= ox_r[gtg_pkg::DIM_W-1] ? gtg_pkg::DIM_W'(~ox_r + gtg_pkg::DIM_W'(1)) : ox_r;
        yn_r <= oy_r[gtg_pkg::DIM_W-1] ? gtg_pkg::DIM_W'(~oy_r + gtg_pkg::DIM_W'(1)) : oy_r;
        wq_r <= '0;
        hq_r <= '0;
        wr_r <= '0;
        hr_r <= '0;
        xr_r <= '0;
        yr_r <= '0;
      end
      gtg_pkg::SU_DIVIDE: begin
        wn_r <= {wn_r[gtg_pkg::DIM_W-2:0], 1'b0};
        hn_r <= {hn_r[gtg_pkg::DIM_W-2:0], 1'b0};
        xn_r <= {xn_r[gtg_pkg::DIM_W-2:0], 1'b0};
        yn_r <= {yn_r[gtg_pkg::DIM_W-2:0], 1'b0};
        wq_r <= {wq_r[gtg_pkg::DIM_W-2:0], ws.q};
        hq_r <= {hq_r[gtg_pkg::DIM_W-2:0], hs.q};
        wr_r <= ws.rem;
        hr_r <= hs.rem;
        xr_r <= xs.rem;
        yr_r <= ys.rem;
      end
      gtg_pkg::SU_FINISH: begin
        oxm_r <= (ox_r[gtg_pkg::DIM_W-1] && (xr_r != '0))
               ? gtg_pkg::POS_W'(w_r - {1'b0, xr_r}) : xr_r;
        oym_r <= (oy_r[gtg_pkg::DIM_W-1] && (yr_r != '0))
               ? gtg_pkg::POS_W'(h_r - {1'b0, yr_r}) : yr_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    setup.rows  = rows_r;
    setup.cols  = cols_r;
    setup.w     = w_r;
    setup.h     = h_r;
    setup.wbase = wq_r;
    setup.hbase = hq_r;
    setup.wres  = wr_r;
    setup.hres  = hr_r;
    setup.oxm   = oxm_r;
    setup.oym   = oym_r;
  end

  assign busy = (state_r != gtg_pkg::SU_READY);

endmodule
